// ----- hdl/lbsc_pkg.sv -----
`timescale 1ns / 1ps

package lbsc_pkg;

  localparam int unsigned ValW   = 24;  // q12.12 values
  localparam int unsigned GainW  = 16;  // q8.8 gains
  localparam int unsigned DtW    = 16;  // q0.16 tick time
  localparam int unsigned OpAW   = 26;  // widest error term
  localparam int unsigned OpBW   = 17;  // gain or zero-extended dt
  localparam int unsigned ProdW  = OpAW + OpBW;
  localparam int unsigned AccW   = 48;
  localparam int unsigned StepW  = 3;
  localparam int unsigned CfgIdxW = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegGainPos   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainVel   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainPitch = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainPRate = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGainYaw   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGainYRate = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStandThr  = 3'd6;

  // order of the products through the shared multiplier
  localparam logic [StepW-1:0] StepVel   = 3'd0;
  localparam logic [StepW-1:0] StepPitch = 3'd1;
  localparam logic [StepW-1:0] StepPRate = 3'd2;
  localparam logic [StepW-1:0] StepPos   = 3'd3;
  localparam logic [StepW-1:0] StepYaw   = 3'd4;
  localparam logic [StepW-1:0] StepYRate = 3'd5;
  localparam logic [StepW-1:0] StepLast  = StepYRate;

  typedef struct packed {
    logic             ofs_mul;
    logic             ofs_add;
    logic             mac_mul;
    logic             mac_acc;
    logic             fin;
    logic [StepW-1:0] step;
  } ctrl_t;

endpackage

// ----- hdl/lbsc_mult.sv -----
`timescale 1ns / 1ps

module lbsc_mult (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [lbsc_pkg::OpAW-1:0]      op_a_i,
  input  logic signed [lbsc_pkg::OpBW-1:0]      op_b_i,
  output logic signed [lbsc_pkg::ProdW-1:0]     prod_o
);
  import lbsc_pkg::*;

  logic signed [ProdW-1:0] prod_d, prod_q;

  assign prod_d = ProdW'(op_a_i) * ProdW'(op_b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/lbsc_seq.sv -----
`timescale 1ns / 1ps

module lbsc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            out_free_i,
  output logic            idle_o,
  output lbsc_pkg::ctrl_t ctrl_o
);
  import lbsc_pkg::*;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StOfsMul = 6'b000010,
    StOfsAdd = 6'b000100,
    StMacMul = 6'b001000,
    StMacAcc = 6'b010000,
    StFin    = 6'b100000
  } state_e;

  state_e           state_d, state_q;
  logic [StepW-1:0] step_d, step_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) state_d = StOfsMul;
      end
      StOfsMul: state_d = StOfsAdd;
      StOfsAdd: begin
        state_d = StMacMul;
        step_d  = StepVel;
      end
      StMacMul: state_d = StMacAcc;
      StMacAcc: begin
        if (step_q == StepLast) begin
          state_d = StFin;
        end else begin
          state_d = StMacMul;
          step_d  = step_q + 3'd1;
        end
      end
      StFin: begin
        if (out_free_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= StepVel;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign idle_o          = (state_q == StIdle);
  assign ctrl_o.ofs_mul  = (state_q == StOfsMul);
  assign ctrl_o.ofs_add  = (state_q == StOfsAdd);
  assign ctrl_o.mac_mul  = (state_q == StMacMul);
  assign ctrl_o.mac_acc  = (state_q == StMacAcc);
  assign ctrl_o.fin      = (state_q == StFin) && out_free_i;
  assign ctrl_o.step     = step_q;

endmodule

// ----- hdl/lqr_balance_steer_control.sv -----
`timescale 1ns / 1ps

// lqr balance and steering controller, one control tick per input item.
// every tick first adds round(target_speed * tick_dt) into a saturating speed
// offset, then forms the balance sum from four q8.8 gains (velocity, pitch,
// pitch rate, position error) and the steering sum from two gains (yaw error,
// yaw rate), all through one shared 26x17 multiplier with a registered product.
// left = sat(balance - steer), right = sat(balance + steer), rounded half up to
// q12.12; both are zero while leg_pos is below the stand threshold or stop is
// set, though the offset is still updated. after accept the sequencer steps
// through an offset product and update, a multiply and an accumulate for each
// of the six products, and a final step that rounds and saturates into the
// output register. input ready is high only while the sequencer is idle, so a
// new item is taken only once the last one is through; the final step waits
// until the output register is free. the result register lets the next item
// be accepted while the last result waits. gain and threshold writes are
// taken in any cycle and must only be made while idle.
module lqr_balance_steer_control (
  input  logic         clk_i,
  input  logic         rst_ni,

  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i,

  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // from bit 0: pos_x, vel_x, pitch_angle, pitch_rate, yaw_angle, yaw_rate,
  // leg_pos, target_x, target_speed, target_yaw (24 each), tick_dt (16),
  // stop (1), zero fill (7)
  input  logic [263:0] s_axis_tdata,

  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // from bit 0: left_drive (24), right_drive (24)
  output logic [47:0]  m_axis_tdata
);
  import lbsc_pkg::*;

  localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

  // configuration registers
  logic signed [GainW-1:0] g_pos_q, g_vel_q, g_pitch_q, g_prate_q, g_yaw_q, g_yrate_q;
  logic signed [ValW-1:0]  thr_q;

  // captured item
  logic signed [ValW-1:0] px_q, vx_q, pa_q, pr_q, ya_q, yr_q, leg_q, tx_q, ts_q, ty_q;
  logic                   stop_q;

  // state and datapath registers
  logic signed [ValW-1:0]  ofs_d, ofs_q;
  logic signed [OpAW-1:0]  op_a_d, op_a_q;
  logic signed [OpBW-1:0]  op_b_d, op_b_q;
  logic signed [AccW-1:0]  acc_b_q, acc_s_q;
  logic                    out_valid_q;
  logic [47:0]             out_data_q;

  logic            accept;
  logic            idle;
  logic            out_free;
  ctrl_t           ctrl;
  logic [StepW-1:0] nstep;
  logic signed [ProdW-1:0] prod;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && idle;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_pos_q   <= 16'sd0;
      g_vel_q   <= -16'sd648;
      g_pitch_q <= -16'sd2993;
      g_prate_q <= -16'sd506;
      g_yaw_q   <= 16'sd533;
      g_yrate_q <= 16'sd108;
      thr_q     <= 24'sd3277;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGainPos:   g_pos_q   <= cfg_data_i[GainW-1:0];
        RegGainVel:   g_vel_q   <= cfg_data_i[GainW-1:0];
        RegGainPitch: g_pitch_q <= cfg_data_i[GainW-1:0];
        RegGainPRate: g_prate_q <= cfg_data_i[GainW-1:0];
        RegGainYaw:   g_yaw_q   <= cfg_data_i[GainW-1:0];
        RegGainYRate: g_yrate_q <= cfg_data_i[GainW-1:0];
        RegStandThr:  thr_q     <= cfg_data_i[ValW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  lbsc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .out_free_i (out_free),
    .idle_o     (idle),
    .ctrl_o     (ctrl)
  );

  lbsc_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (ctrl.ofs_mul || ctrl.mac_mul),
    .op_a_i (op_a_q),
    .op_b_i (op_b_q),
    .prod_o (prod)
  );

  // offset step: round half up the q12.28 product back to q12.12, add, saturate
  logic signed [ProdW-1:0] ofs_round;
  logic signed [ValW+3:0]  ofs_sum;

  assign ofs_round = prod + ProdW'(32768);
  assign ofs_sum   = {{4{ofs_q[ValW-1]}}, ofs_q}
                   + {ofs_round[ProdW-1], ofs_round[ProdW-1:16]};

  always_comb begin
    ofs_d = ofs_q;
    if (ctrl.ofs_add) begin
      if (ofs_sum > (ValW+4)'(ValMax))      ofs_d = ValMax;
      else if (ofs_sum < (ValW+4)'(ValMin)) ofs_d = ValMin;
      else                                  ofs_d = ofs_sum[ValW-1:0];
    end
  end

  // operands for the next product; the position error goes after the offset update
  assign nstep = ctrl.ofs_add ? StepVel : ctrl.step + 3'd1;

  always_comb begin
    op_a_d = op_a_q;
    op_b_d = op_b_q;
    if (accept) begin
      op_a_d = {{2{s_axis_tdata[215]}}, s_axis_tdata[215:192]};
      op_b_d = {1'b0, s_axis_tdata[255:240]};
    end else if (ctrl.ofs_add || (ctrl.mac_acc && ctrl.step != StepLast)) begin
      case (nstep)
        StepVel: begin
          op_a_d = {{2{vx_q[ValW-1]}}, vx_q} - {{2{ts_q[ValW-1]}}, ts_q};
          op_b_d = {g_vel_q[GainW-1], g_vel_q};
        end
        StepPitch: begin
          op_a_d = {{2{pa_q[ValW-1]}}, pa_q} - {{2{tx_q[ValW-1]}}, tx_q};
          op_b_d = {g_pitch_q[GainW-1], g_pitch_q};
        end
        StepPRate: begin
          op_a_d = {{2{pr_q[ValW-1]}}, pr_q};
          op_b_d = {g_prate_q[GainW-1], g_prate_q};
        end
        StepPos: begin
          op_a_d = {{2{px_q[ValW-1]}}, px_q} - {{2{tx_q[ValW-1]}}, tx_q}
                 - {{2{ofs_q[ValW-1]}}, ofs_q};
          op_b_d = {g_pos_q[GainW-1], g_pos_q};
        end
        StepYaw: begin
          op_a_d = {{2{ya_q[ValW-1]}}, ya_q} - {{2{ty_q[ValW-1]}}, ty_q};
          op_b_d = {g_yaw_q[GainW-1], g_yaw_q};
        end
        StepYRate: begin
          op_a_d = {{2{yr_q[ValW-1]}}, yr_q};
          op_b_d = {g_yrate_q[GainW-1], g_yrate_q};
        end
        default: begin
          op_a_d = '0;
          op_b_d = '0;
        end
      endcase
    end
  end

  // final rounding and saturation
  logic signed [AccW-1:0] sum_l, sum_r;
  logic signed [ValW-1:0] left_v, right_v;
  logic                   hold;

  assign sum_l = acc_b_q - acc_s_q + AccW'(128);
  assign sum_r = acc_b_q + acc_s_q + AccW'(128);
  assign hold  = (leg_q < thr_q) || stop_q;

  always_comb begin
    if ($signed(sum_l[AccW-1:8]) > (AccW-8)'(ValMax))      left_v = ValMax;
    else if ($signed(sum_l[AccW-1:8]) < (AccW-8)'(ValMin)) left_v = ValMin;
    else                                                   left_v = sum_l[ValW+7:8];
    if ($signed(sum_r[AccW-1:8]) > (AccW-8)'(ValMax))      right_v = ValMax;
    else if ($signed(sum_r[AccW-1:8]) < (AccW-8)'(ValMin)) right_v = ValMin;
    else                                                   right_v = sum_r[ValW+7:8];
    if (hold) begin
      left_v  = '0;
      right_v = '0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= s_axis_tdata[23:0];
      vx_q   <= s_axis_tdata[47:24];
      pa_q   <= s_axis_tdata[71:48];
      pr_q   <= s_axis_tdata[95:72];
      ya_q   <= s_axis_tdata[119:96];
      yr_q   <= s_axis_tdata[143:120];
      leg_q  <= s_axis_tdata[167:144];
      tx_q   <= s_axis_tdata[191:168];
      ts_q   <= s_axis_tdata[215:192];
      ty_q   <= s_axis_tdata[239:216];
      stop_q <= s_axis_tdata[256];
    end
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
    if (accept) begin
      acc_b_q <= '0;
      acc_s_q <= '0;
    end else if (ctrl.mac_acc) begin
      // balance products first, then steering
      if (ctrl.step < StepYaw) acc_b_q <= acc_b_q + AccW'(prod);
      else                     acc_s_q <= acc_s_q + AccW'(prod);
    end
    if (ctrl.fin) begin
      out_data_q <= {right_v, left_v};
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ofs_q <= ofs_d;
      if (ctrl.fin)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
